// ===== rtl/fdc_pkg.sv =====
`default_nettype none

package fdc_pkg;

  // Fixed field widths.
  localparam int unsigned NW    = 16;          // query operand
  localparam int unsigned CW    = 30;          // divisor count
  localparam int unsigned EW    = 17;          // exponent plus one, up to 2^16
  localparam int unsigned PW    = NW + 1;      // prime candidate, may reach n + 1
  localparam int unsigned PRODW = CW + EW;     // product before reduction
  localparam int unsigned CNTW  = 5;           // step counter, holds up to EW - 1

  localparam int unsigned MAX_N_DEF = 65536;

  localparam logic [CW-1:0] DIV_MOD = 30'd1000000007;

  typedef struct packed {
    logic clr_step;
    logic p_init;
    logic p_inc;
    logic mem_rd;
    logic mark_init;
    logic mark_step;
    logic q_load;
    logic ex_init;
    logic div_start;
    logic div_step;
    logic div_commit;
    logic mul_load;
    logic red_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sv_end;
    logic flag;
    logic mark_end;
    logic p_gt_n;
    logic q_lt_p;
    logic cnt_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/fdc_in_if.sv =====
`default_nettype none

interface fdc_in_if;
  logic                   valid;
  logic                   ready;
  logic [fdc_pkg::NW-1:0] n;

  modport source (output valid, output n, input ready);
  modport sink   (input valid, input n, output ready);
endinterface

`default_nettype wire

// ===== rtl/fdc_out_if.sv =====
`default_nettype none

interface fdc_out_if;
  logic                   valid;
  logic                   ready;
  logic [fdc_pkg::CW-1:0] divisor_count;

  modport source (output valid, output divisor_count, input ready);
  modport sink   (input valid, input divisor_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/fdc_datapath.sv =====
`default_nettype none

module fdc_datapath #(
  parameter int unsigned MAX_N = fdc_pkg::MAX_N_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fdc_pkg::cmd_t          cmd,
  output fdc_pkg::sts_t          sts,
  input  logic [fdc_pkg::NW-1:0] in_n,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [fdc_pkg::CW-1:0] out_count
);

  localparam int unsigned NW    = fdc_pkg::NW;
  localparam int unsigned CW    = fdc_pkg::CW;
  localparam int unsigned EW    = fdc_pkg::EW;
  localparam int unsigned PW    = fdc_pkg::PW;
  localparam int unsigned PRODW = fdc_pkg::PRODW;
  localparam int unsigned CNTW  = fdc_pkg::CNTW;
  localparam int unsigned AW    = $clog2(MAX_N);
  localparam int unsigned IW    = AW + 1;
  localparam int unsigned PPW   = 2 * PW;

  localparam logic [IW-1:0] TOP_IDX  = IW'(MAX_N);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_N - 1);
  localparam logic [31:0]   N_LIMIT  = 32'(MAX_N - 1);

  // Primality bitmap.
  logic          flags_mem [MAX_N];
  logic          rd_flag_r;
  logic          mem_we;
  logic          wr_bit;
  logic [AW-1:0] wr_addr;

  logic [IW-1:0]    idx_r;
  logic [PW-1:0]    p_r;
  logic [PPW-1:0]   pp;
  logic [NW-1:0]    n_r;
  logic [NW-1:0]    n_sat;
  logic [NW-1:0]    q_r;
  logic [NW-1:0]    dq_r;
  logic [NW-1:0]    rem_r;
  logic [NW:0]      rem_sh;
  logic [NW:0]      rem_diff;
  logic             rem_ge;
  logic [EW-1:0]    e_r;
  logic [EW-1:0]    e_inc;
  logic [CW-1:0]    res_r;
  logic [PRODW-1:0] prod_r;
  logic [PRODW-1:0] mk_r;
  logic [PRODW-1:0] mul_full;
  logic [PRODW-1:0] red_val;
  logic [CNTW-1:0]  cnt_r;
  logic             out_valid_r;
  logic [CW-1:0]    out_count_r;

  assign mem_we  = cmd.clr_step | cmd.mark_step;
  assign wr_addr = idx_r[AW-1:0];
  // The clearing sweep marks everything from two upwards as prime; marking writes zero.
  assign wr_bit  = cmd.clr_step & (idx_r >= IW'(2));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      flags_mem[wr_addr] <= wr_bit;
    end
    if (cmd.mem_rd) begin
      rd_flag_r <= flags_mem[AW'(p_r)];
    end
  end

  assign pp    = PPW'(p_r) * PPW'(p_r);
  assign n_sat = (32'(in_n) > N_LIMIT) ? NW'(N_LIMIT) : in_n;

  // One quotient bit per cycle.
  assign rem_sh   = {rem_r, dq_r[NW-1]};
  assign rem_ge   = rem_sh >= p_r;
  assign rem_diff = rem_sh - p_r;

  assign e_inc    = e_r + EW'(1);
  assign mul_full = res_r * e_inc;
  assign red_val  = (prod_r >= mk_r) ? (prod_r - mk_r) : prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        idx_r <= idx_r + IW'(1);
      end else if (cmd.mark_init) begin
        idx_r <= IW'(pp);
      end else if (cmd.mark_step) begin
        idx_r <= idx_r + IW'(p_r);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.p_init) begin
      p_r <= PW'(2);
    end else if (cmd.p_inc) begin
      p_r <= p_r + PW'(1);
    end
    if (cmd.q_load) begin
      n_r   <= n_sat;
      res_r <= CW'(1);
    end
    if (cmd.ex_init) begin
      q_r <= n_r;
      e_r <= '0;
    end else if (cmd.div_commit) begin
      q_r <= dq_r;
      e_r <= e_r + EW'(dq_r);
    end
    if (cmd.div_start) begin
      dq_r  <= q_r;
      rem_r <= '0;
      cnt_r <= CNTW'(NW - 1);
    end else if (cmd.div_step) begin
      dq_r  <= {dq_r[NW-2:0], rem_ge};
      rem_r <= rem_ge ? rem_diff[NW-1:0] : rem_sh[NW-1:0];
      cnt_r <= cnt_r - CNTW'(1);
    end else if (cmd.mul_load) begin
      // Product stays below the modulus times 2^EW, so EW conditional subtractions reduce it.
      prod_r <= mul_full;
      mk_r   <= PRODW'(fdc_pkg::DIV_MOD) << (EW - 1);
      cnt_r  <= CNTW'(EW - 1);
    end else if (cmd.red_step) begin
      prod_r <= red_val;
      mk_r   <= mk_r >> 1;
      cnt_r  <= cnt_r - CNTW'(1);
      if (cnt_r == '0) begin
        res_r <= red_val[CW-1:0];
      end
    end
    if (cmd.out_load) begin
      out_count_r <= res_r;
    end
  end

  assign sts.clr_last = idx_r == LAST_IDX;
  assign sts.sv_end   = pp >= PPW'(MAX_N);
  assign sts.flag     = rd_flag_r;
  assign sts.mark_end = idx_r >= TOP_IDX;
  assign sts.p_gt_n   = p_r > {1'b0, n_r};
  assign sts.q_lt_p   = {1'b0, q_r} < p_r;
  assign sts.cnt_zero = cnt_r == '0;
  assign sts.out_free = !out_valid_r | out_ready;

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

endmodule

`default_nettype wire

// ===== rtl/fdc_ctrl.sv =====
`default_nettype none

module fdc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fdc_pkg::sts_t sts,
  output fdc_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_CLR,
    ST_SV_RD,
    ST_SV_FLAG,
    ST_MARK,
    ST_IDLE,
    ST_Q_RD,
    ST_Q_FLAG,
    ST_EX_CHK,
    ST_DIV,
    ST_DIV_END,
    ST_RED,
    ST_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.p_init = 1'b1;
          state_nxt  = ST_SV_RD;
        end
      end
      ST_SV_RD: begin
        if (sts.sv_end) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = ST_SV_FLAG;
        end
      end
      ST_SV_FLAG: begin
        if (sts.flag) begin
          cmd.mark_init = 1'b1;
          state_nxt     = ST_MARK;
        end else begin
          cmd.p_inc = 1'b1;
          state_nxt = ST_SV_RD;
        end
      end
      ST_MARK: begin
        if (sts.mark_end) begin
          cmd.p_inc = 1'b1;
          state_nxt = ST_SV_RD;
        end else begin
          cmd.mark_step = 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.q_load = 1'b1;
          cmd.p_init = 1'b1;
          state_nxt  = ST_Q_RD;
        end
      end
      ST_Q_RD: begin
        if (sts.p_gt_n) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = ST_Q_FLAG;
        end
      end
      ST_Q_FLAG: begin
        if (sts.flag) begin
          cmd.ex_init = 1'b1;
          state_nxt   = ST_EX_CHK;
        end else begin
          cmd.p_inc = 1'b1;
          state_nxt = ST_Q_RD;
        end
      end
      ST_EX_CHK: begin
        // Once the running quotient drops below p the exponent is complete.
        if (sts.q_lt_p) begin
          cmd.mul_load = 1'b1;
          state_nxt    = ST_RED;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_zero) begin
          state_nxt = ST_DIV_END;
        end
      end
      ST_DIV_END: begin
        cmd.div_commit = 1'b1;
        state_nxt      = ST_EX_CHK;
      end
      ST_RED: begin
        cmd.red_step = 1'b1;
        if (sts.cnt_zero) begin
          cmd.p_inc = 1'b1;
          state_nxt = ST_Q_RD;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/factorial_divisor_count_unit.sv =====
`default_nettype none

// Counts the divisors of n! modulo 1000000007 for a 16-bit n, one word in and one word out,
// with n saturated to MAX_N - 1. After reset the block is not ready while it clears the
// primality bitmap and then runs the sieve: each candidate p with p*p below MAX_N is read,
// and each prime found writes zero over its multiples from p*p up to MAX_N - 1. A query
// then walks every integer from 2 to n through the bitmap read port; each prime p takes
// one pass of the bit-serial divider for every power p^k <= n, then the multiply and the
// serial modular reduction. One query is worked at a time; a finished result waits in the
// output register while the next word is taken.
module factorial_divisor_count_unit #(
  parameter int unsigned MAX_N = fdc_pkg::MAX_N_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  fdc_in_if.sink           in_chan,
  fdc_out_if.source        out_chan
);

  fdc_pkg::cmd_t cmd;
  fdc_pkg::sts_t sts;

  fdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fdc_datapath #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_n      (in_chan.n),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_count (out_chan.divisor_count)
  );

  // A query occupies the block, so no second word is taken straight after one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input taken while a query is in progress");

  // The reduction must leave a residue.
  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.divisor_count < fdc_pkg::DIV_MOD))
    else $error("result not reduced below the modulus");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_chan.valid || out_chan.ready))
    else $error("result register overwritten");

endmodule

`default_nettype wire
